### src/interrupt_vector_allocator_macros.svh
// ----------------------------------------------------------------------------
// Interrupt vector allocator assertion macros
// Assertion wrappers that are clocked by clk and held off by arst_n.
// ----------------------------------------------------------------------------
`ifndef INTERRUPT_VECTOR_ALLOCATOR_MACROS_SVH
`define INTERRUPT_VECTOR_ALLOCATOR_MACROS_SVH

`ifndef ASSERT_OFF
`define IVALLOC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define IVALLOC_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define IVALLOC_ASSERT(lbl, prop, msg)
`define IVALLOC_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

### src/ivalloc_pkg.sv
// ----------------------------------------------------------------------------
// Interrupt vector allocator package
// Request codes, beat layout widths and the controller command bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package ivalloc_pkg;

	localparam int OP_W      = 3;
	localparam int VEC_W     = 8;
	localparam int WORD_W    = 32;
	localparam int VOUT_W    = 7;
	localparam int IN_DATA_W = 80;
	localparam int OUT_DATA_W = 80;
	localparam int GRP_W     = 3;
	localparam int ALLOC_W   = 6;

	localparam logic [OP_W-1:0] OP_ALLOCATE   = 3'd0;
	localparam logic [OP_W-1:0] OP_FREE       = 3'd1;
	localparam logic [OP_W-1:0] OP_REGISTER   = 3'd2;
	localparam logic [OP_W-1:0] OP_UNREGISTER = 3'd3;
	localparam logic [OP_W-1:0] OP_DISPATCH   = 3'd4;

	typedef struct packed {
		logic load;
		logic exec;
		logic commit;
	} ivalloc_cmd_t;

endpackage

`default_nettype wire

### src/interrupt_vector_allocator.sv
// ----------------------------------------------------------------------------
// Interrupt vector allocator
// Allocates driver interrupt vectors and keeps a handler and context word
// for each of them.
// ----------------------------------------------------------------------------
// Each request gives exactly one result beat. A request passes a read cycle
// and a commit cycle: the read cycle reads the handler memory and registers
// the per-group free search, the commit cycle picks the lowest free entry,
// updates the table and loads the output register; in that same cycle the
// next request can be taken while the output side keeps up. The handler
// memory needs no clearing after reset because a presence bit per entry marks
// which handlers are valid, so requests are taken right after reset.
`default_nettype none

`include "interrupt_vector_allocator_macros.svh"

module interrupt_vector_allocator
	import ivalloc_pkg::*;
#(
	parameter int FIRST_VECTOR = 64,
	parameter int VECTOR_COUNT = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// Fields from bit 0: op[2:0], vector[10:3], handler_token[42:11],
	// context_value[74:43], zero fill[79:75].
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// Fields from bit 0: status[0], vector_out[7:1], call_valid[8],
	// call_handler[40:9], call_context[72:41], zero fill[79:73].
	output logic      [OUT_DATA_W-1:0] m_tdata
);

	ivalloc_cmd_t cmd;

	ivalloc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	ivalloc_dpath #(
		.FIRST_VECTOR (FIRST_VECTOR),
		.VECTOR_COUNT (VECTOR_COUNT)
	) u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.s_tdata (s_tdata),
		.m_tdata (m_tdata)
	);

	`IVALLOC_ASSERT_NEXT(a_load_then_exec, cmd.load, cmd.exec, "accepted beat did not start a read")
	`IVALLOC_ASSERT(a_ready_not_exec, s_tready |-> !cmd.exec, "ready during table read")
	`IVALLOC_ASSERT_NEXT(a_commit_valid, cmd.commit, m_tvalid, "commit did not present a result")

endmodule

`default_nettype wire

### src/ivalloc_ctrl.sv
// ----------------------------------------------------------------------------
// Interrupt vector allocator controller
// Sequences each request through a table read cycle and a commit cycle and
// owns the handshakes of both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module ivalloc_ctrl
	import ivalloc_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output ivalloc_cmd_t      cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_EXEC   = 2'd1;
	localparam logic [1:0] ST_FINISH = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nxt;
	logic       m_valid_q;
	logic       can_load;
	logic       accept;

	assign can_load = !m_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) || ((state_q == ST_FINISH) && can_load);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_valid_q;

	assign cmd.load   = accept;
	assign cmd.exec   = (state_q == ST_EXEC);
	assign cmd.commit = (state_q == ST_FINISH) && can_load;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_nxt = ST_EXEC;
			end
			ST_EXEC: begin
				state_nxt = ST_FINISH;
			end
			ST_FINISH: begin
				if (can_load) state_nxt = accept ? ST_EXEC : ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.commit) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

### src/ivalloc_dpath.sv
// ----------------------------------------------------------------------------
// Interrupt vector allocator datapath
// Holds the allocation marks, handler presence bits and the handler and
// context memory, finds the lowest free entry and forms each result.
// ----------------------------------------------------------------------------
`default_nettype none

module ivalloc_dpath
	import ivalloc_pkg::*;
#(
	parameter int FIRST_VECTOR = 64,
	parameter int VECTOR_COUNT = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire ivalloc_cmd_t          cmd,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	output logic      [OUT_DATA_W-1:0] m_tdata
);

	localparam int IDX_W = (VECTOR_COUNT > 1) ? $clog2(VECTOR_COUNT) : 1;
	localparam int NG    = (VECTOR_COUNT + 7) / 8;

	logic [OP_W-1:0]         op_q;
	logic [VEC_W-1:0]        vec_q;
	logic [WORD_W-1:0]       tok_q;
	logic [WORD_W-1:0]       ctx_q;

	logic [VECTOR_COUNT-1:0] marks_q;
	logic [VECTOR_COUNT-1:0] hv_q;
	logic [2*WORD_W-1:0]     mem [VECTOR_COUNT];
	logic [2*WORD_W-1:0]     rd_q;

	logic [NG*8-1:0]         free_pad;
	logic [NG-1:0]           grp_any;
	logic [GRP_W-1:0]        grp_loc [NG];
	logic [NG-1:0]           grp_any_s1;
	logic [GRP_W-1:0]        grp_loc_s1 [NG];

	logic [VEC_W:0]          diff;
	logic                    hit;
	logic [IDX_W-1:0]        idx;
	logic                    alloc_found;
	logic [ALLOC_W-1:0]      alloc_idx;
	logic [VEC_W:0]          alloc_vec;
	logic                    reg_ok;

	logic                    status_d;
	logic [VOUT_W-1:0]       vout_d;
	logic                    cvalid_d;
	logic [WORD_W-1:0]       chand_d;
	logic [WORD_W-1:0]       cctx_d;

	logic                    status_q;
	logic [VOUT_W-1:0]       vout_q;
	logic                    cvalid_q;
	logic [WORD_W-1:0]       chand_q;
	logic [WORD_W-1:0]       cctx_q;

	assign diff = {1'b0, vec_q} - (VEC_W+1)'(FIRST_VECTOR);
	assign hit  = ({1'b0, vec_q} >= (VEC_W+1)'(FIRST_VECTOR)) &&
	              (diff < (VEC_W+1)'(VECTOR_COUNT));
	assign idx  = hit ? diff[IDX_W-1:0] : '0;

	always_comb begin
		free_pad                   = '0;
		free_pad[VECTOR_COUNT-1:0] = ~marks_q;
		for (int g = 0; g < NG; g++) begin
			grp_any[g] = |free_pad[g*8 +: 8];
			grp_loc[g] = '0;
			for (int b = 7; b >= 0; b--) begin
				if (free_pad[g*8 + b]) grp_loc[g] = GRP_W'(b);
			end
		end
	end

	always_comb begin
		alloc_found = 1'b0;
		alloc_idx   = '0;
		for (int g = NG - 1; g >= 0; g--) begin
			if (grp_any_s1[g]) begin
				alloc_found = 1'b1;
				alloc_idx   = {GRP_W'(g), grp_loc_s1[g]};
			end
		end
	end

	assign alloc_vec = (VEC_W+1)'(FIRST_VECTOR) + (VEC_W+1)'(alloc_idx);
	assign reg_ok    = hit && (tok_q != '0) && marks_q[idx] && !hv_q[idx];

	always_comb begin
		status_d = 1'b0;
		vout_d   = '0;
		cvalid_d = 1'b0;
		chand_d  = '0;
		cctx_d   = '0;
		unique case (op_q)
			OP_ALLOCATE: begin
				status_d = !alloc_found;
				vout_d   = alloc_found ? alloc_vec[VOUT_W-1:0] : '0;
			end
			OP_REGISTER: begin
				status_d = !reg_ok;
			end
			OP_DISPATCH: begin
				cvalid_d = hit && hv_q[idx];
				chand_d  = cvalid_d ? rd_q[WORD_W-1:0] : '0;
				cctx_d   = cvalid_d ? rd_q[2*WORD_W-1:WORD_W] : '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= s_tdata[2:0];
			vec_q <= s_tdata[10:3];
			tok_q <= s_tdata[42:11];
			ctx_q <= s_tdata[74:43];
		end
		if (cmd.exec) begin
			grp_any_s1 <= grp_any;
			for (int g = 0; g < NG; g++) begin
				grp_loc_s1[g] <= grp_loc[g];
			end
			rd_q <= mem[idx];
		end
		if (cmd.commit && (op_q == OP_REGISTER) && reg_ok) begin
			mem[idx] <= {ctx_q, tok_q};
		end
		if (cmd.commit) begin
			status_q <= status_d;
			vout_q   <= vout_d;
			cvalid_q <= cvalid_d;
			chand_q  <= chand_d;
			cctx_q   <= cctx_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marks_q <= '0;
			hv_q    <= '0;
		end else if (cmd.commit) begin
			unique case (op_q)
				OP_ALLOCATE: begin
					if (alloc_found) marks_q[alloc_idx[IDX_W-1:0]] <= 1'b1;
				end
				OP_FREE: begin
					if (hit) begin
						marks_q[idx] <= 1'b0;
						hv_q[idx]    <= 1'b0;
					end
				end
				OP_REGISTER: begin
					if (reg_ok) hv_q[idx] <= 1'b1;
				end
				OP_UNREGISTER: begin
					if (hit) hv_q[idx] <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	assign m_tdata = {7'b0, cctx_q, chand_q, cvalid_q, vout_q, status_q};

endmodule

`default_nettype wire

### dv/interrupt_vector_allocator_tb.sv
// ----------------------------------------------------------------------------
// Interrupt vector allocator testbench
// Sends allocate, free, register, unregister and dispatch requests as stream
// beats, first from a table of hand-picked cases and then in random phases
// that fill, churn and drain the vector table. Every result beat is compared
// with the output of a behavioral model of the table, or with the answer
// typed into the table where it is obvious.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module interrupt_vector_allocator_tb;
	import ivalloc_pkg::*;

	localparam int FIRST_VECTOR = 64;
	localparam int VECTOR_COUNT = 64;
	localparam int RANDOM_ITEMS = 1625;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_AFTER   = 300;
	localparam int HOLD_CYCLES  = 400;
	localparam int SETTLE_CYCLES = 8;

	localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
	localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

	typedef struct packed {
		logic              status;
		logic [VOUT_W-1:0] vector_out;
		logic              call_valid;
		logic [WORD_W-1:0] call_handler;
		logic [WORD_W-1:0] call_context;
	} alloc_result_t;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [VEC_W-1:0]  vector;
		logic [WORD_W-1:0] token;
		logic [WORD_W-1:0] context_word;
		logic              fixed;
		alloc_result_t     answer;
	} request_row_t;

	typedef enum logic [1:0] {
		PH_FILL,
		PH_CHURN,
		PH_DRAIN,
		PH_NOISE
	} phase_kind_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;

	logic          row_fixed;
	alloc_result_t row_answer;

	logic              owned_marks [VECTOR_COUNT];
	logic [WORD_W-1:0] handler_words [VECTOR_COUNT];
	logic [WORD_W-1:0] context_words [VECTOR_COUNT];

	alloc_result_t pending_results [$];
	request_row_t  directed_rows [$];

	int  mismatches;
	int  results_seen;
	int  cycle_count;
	int  burst_left;
	bit  hold_active;
	bit  hold_done;

	interrupt_vector_allocator #(
		.FIRST_VECTOR (FIRST_VECTOR),
		.VECTOR_COUNT (VECTOR_COUNT)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic alloc_result_t predict_request(input logic [OP_W-1:0] op,
			input logic [VEC_W-1:0] vec, input logic [WORD_W-1:0] tok,
			input logic [WORD_W-1:0] ctx);
		alloc_result_t r;
		int  v;
		int  idx;
		int  i;
		bit  hit;
		bit  found;
		r = '0;
		v = int'(vec);
		idx = v - FIRST_VECTOR;
		hit = (v >= FIRST_VECTOR) && (idx < VECTOR_COUNT);
		found = 1'b0;
		case (op)
			OP_ALLOCATE: begin
				r.status = 1'b1;
				for (i = 0; i < VECTOR_COUNT; i++) begin
					if (!found && !owned_marks[i]) begin
						found = 1'b1;
						owned_marks[i] = 1'b1;
						r.status = 1'b0;
						r.vector_out = VOUT_W'(FIRST_VECTOR + i);
					end
				end
			end
			OP_FREE: begin
				if (hit) begin
					owned_marks[idx] = 1'b0;
					handler_words[idx] = '0;
					context_words[idx] = '0;
				end
			end
			OP_REGISTER: begin
				if (!hit || tok == '0 || !owned_marks[idx] || handler_words[idx] != '0) begin
					r.status = 1'b1;
				end else begin
					handler_words[idx] = tok;
					context_words[idx] = ctx;
				end
			end
			OP_UNREGISTER: begin
				if (hit) begin
					handler_words[idx] = '0;
					context_words[idx] = '0;
				end
			end
			OP_DISPATCH: begin
				if (hit && handler_words[idx] != '0) begin
					r.call_valid = 1'b1;
					r.call_handler = handler_words[idx];
					r.call_context = context_words[idx];
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic int free_entries();
		int n;
		n = 0;
		for (int i = 0; i < VECTOR_COUNT; i++)
			if (!owned_marks[i])
				n++;
		return n;
	endfunction

	function automatic logic [VEC_W-1:0] owned_vector();
		int start;
		int idx;
		start = $urandom_range(0, VECTOR_COUNT - 1);
		for (int i = 0; i < VECTOR_COUNT; i++) begin
			idx = (start + i) % VECTOR_COUNT;
			if (owned_marks[idx])
				return VEC_W'(FIRST_VECTOR + idx);
		end
		return VEC_W'(FIRST_VECTOR + start);
	endfunction

	function automatic logic [WORD_W-1:0] random_word();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 8)
			return '0;
		if (roll < 14)
			return '1;
		return $urandom;
	endfunction

	task automatic make_request(input phase_kind_t kind, output logic [OP_W-1:0] op,
			output logic [VEC_W-1:0] vec, output logic [WORD_W-1:0] tok,
			output logic [WORD_W-1:0] ctx);
		int roll;
		int pick;
		roll = $urandom_range(0, 99);
		pick = $urandom_range(0, 99);
		case (kind)
			PH_FILL:
				op = roll < 60 ? OP_ALLOCATE : roll < 80 ? OP_REGISTER :
					roll < 92 ? OP_DISPATCH : roll < 96 ? OP_UNREGISTER : OP_FREE;
			PH_CHURN:
				op = roll < 20 ? OP_ALLOCATE : roll < 35 ? OP_FREE :
					roll < 60 ? OP_REGISTER : roll < 70 ? OP_UNREGISTER :
					roll < 95 ? OP_DISPATCH : OP_W'(OP_RSVD_5 + $urandom_range(0, 2));
			PH_DRAIN:
				op = roll < 55 ? OP_FREE : roll < 75 ? OP_UNREGISTER :
					roll < 90 ? OP_DISPATCH : OP_REGISTER;
			default:
				op = OP_W'($urandom_range(OP_ALLOCATE, OP_RSVD_7));
		endcase
		if (kind == PH_NOISE || pick < 15)
			vec = VEC_W'($urandom);
		else if (pick < 65)
			vec = owned_vector();
		else
			vec = VEC_W'(FIRST_VECTOR + $urandom_range(0, VECTOR_COUNT - 1));
		tok = random_word();
		ctx = random_word();
	endtask

	// Offers one request beat, waits for it to be taken, then, when the burst has
	// run out, starts a new burst, usually after a gap.
	task automatic offer(input logic [OP_W-1:0] op, input logic [VEC_W-1:0] vec,
			input logic [WORD_W-1:0] tok, input logic [WORD_W-1:0] ctx,
			input logic fixed, input alloc_result_t answer);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_DATA_W - OP_W - VEC_W - 2 * WORD_W){1'b0}}, ctx, tok, vec, op};
		row_fixed <= fixed;
		row_answer <= answer;
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic add_row(input logic [OP_W-1:0] op, input int vec,
			input logic [WORD_W-1:0] tok, input logic [WORD_W-1:0] ctx,
			input int fixed, input int st, input int vout, input int cv,
			input logic [WORD_W-1:0] ch, input logic [WORD_W-1:0] cc);
		request_row_t row;
		row.op = op;
		row.vector = VEC_W'(vec);
		row.token = tok;
		row.context_word = ctx;
		row.fixed = (fixed != 0);
		row.answer.status = (st != 0);
		row.answer.vector_out = VOUT_W'(vout);
		row.answer.call_valid = (cv != 0);
		row.answer.call_handler = ch;
		row.answer.call_context = cc;
		directed_rows.push_back(row);
	endtask

	task automatic report_beat(input string what, input alloc_result_t want,
			input alloc_result_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: expected st=%0d vec=%0d cv=%0d h=%h c=%h, got st=%0d vec=%0d cv=%0d h=%h c=%h",
				$realtime, what, want.status, want.vector_out, want.call_valid,
				want.call_handler, want.call_context, got.status, got.vector_out,
				got.call_valid, got.call_handler, got.call_context);
	endtask

	always @(posedge clk) begin
		alloc_result_t predicted;
		if (arst_n && s_tvalid && s_tready) begin
			predicted = predict_request(s_tdata[2:0], s_tdata[10:3], s_tdata[42:11],
				s_tdata[74:43]);
			pending_results.push_back(row_fixed ? row_answer : predicted);
		end
	end

	always @(posedge clk) begin
		alloc_result_t got;
		alloc_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			got.status = m_tdata[0];
			got.vector_out = m_tdata[7:1];
			got.call_valid = m_tdata[8];
			got.call_handler = m_tdata[40:9];
			got.call_context = m_tdata[72:41];
			if (pending_results.size() == 0) begin
				report_beat("unexpected result beat", '0, got);
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status || got.vector_out !== want.vector_out ||
						got.call_valid !== want.call_valid ||
						got.call_handler !== want.call_handler ||
						got.call_context !== want.call_context)
					report_beat("result mismatch", want, got);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Result side: random ready patterns, plus one long hold-off once traffic
	// is flowing so that the block backs up into its request port.
	initial begin
		int stall_left;
		int pattern_left;
		int mode;
		stall_left = 0;
		pattern_left = 0;
		mode = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (arst_n && !hold_done && results_seen >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_active = 1'b1;
				stall_left = HOLD_CYCLES - 1;
				m_tready <= 1'b0;
			end else begin
				hold_active = 1'b0;
				if (pattern_left == 0) begin
					mode = $urandom_range(0, 2);
					pattern_left = $urandom_range(8, 64);
				end
				pattern_left--;
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 3) != 0);
					default: m_tready <= ($urandom_range(0, 1) != 0);
				endcase
			end
		end
	end

	initial begin
		logic [OP_W-1:0]   op;
		logic [VEC_W-1:0]  vec;
		logic [WORD_W-1:0] tok;
		logic [WORD_W-1:0] ctx;
		phase_kind_t       kind;
		int                sent;
		int                phase_len;
		int                overflow_tries;
		int                n;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		row_fixed = 1'b0;
		row_answer = '0;
		mismatches = 0;
		results_seen = 0;
		cycle_count = 0;
		burst_left = 1;
		hold_active = 1'b0;
		hold_done = 1'b0;
		for (int i = 0; i < VECTOR_COUNT; i++) begin
			owned_marks[i] = 1'b0;
			handler_words[i] = '0;
			context_words[i] = '0;
		end

		// Fixed answers: empty table after reset, register refusals, extremes
		// of the token and context words, ignored out-of-range vectors and the
		// unused op codes.
		add_row(OP_DISPATCH, 64, 0, 0, 1, 0, 0, 0, 0, 0);
		add_row(OP_ALLOCATE, 0, 0, 0, 1, 0, 64, 0, 0, 0);
		add_row(OP_REGISTER, 64, 0, '1, 1, 1, 0, 0, 0, 0);
		add_row(OP_REGISTER, 64, '1, '1, 1, 0, 0, 0, 0, 0);
		add_row(OP_REGISTER, 64, 1, 1, 1, 1, 0, 0, 0, 0);
		add_row(OP_DISPATCH, 64, 0, 0, 1, 0, 0, 1, '1, '1);
		add_row(OP_REGISTER, 65, 5, 5, 1, 1, 0, 0, 0, 0);
		add_row(OP_REGISTER, 63, 5, 5, 1, 1, 0, 0, 0, 0);
		add_row(OP_REGISTER, 128, 5, 5, 1, 1, 0, 0, 0, 0);
		add_row(OP_REGISTER, 255, '1, '1, 1, 1, 0, 0, 0, 0);
		add_row(OP_REGISTER, 0, 5, 5, 1, 1, 0, 0, 0, 0);
		add_row(OP_FREE, 0, 0, 0, 1, 0, 0, 0, 0, 0);
		add_row(OP_UNREGISTER, 255, 0, 0, 1, 0, 0, 0, 0, 0);
		add_row(OP_DISPATCH, 127, 0, 0, 1, 0, 0, 0, 0, 0);
		add_row(OP_ALLOCATE, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(OP_REGISTER, 65, 32'ha5a5a5a5, 32'h5a5a5a5a, 0, 0, 0, 0, 0, 0);
		add_row(OP_UNREGISTER, 64, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(OP_DISPATCH, 64, 0, 0, 1, 0, 0, 0, 0, 0);
		add_row(OP_DISPATCH, 65, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(OP_FREE, 64, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(OP_ALLOCATE, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(OP_RSVD_5, 255, '1, '1, 1, 0, 0, 0, 0, 0);
		add_row(OP_RSVD_7, 65, '1, '1, 1, 0, 0, 0, 0, 0);
		add_row(OP_RSVD_6, 0, 0, 0, 1, 0, 0, 0, 0, 0);
		add_row(OP_FREE, 65, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(OP_DISPATCH, 65, 0, 0, 0, 0, 0, 0, 0, 0);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			offer(directed_rows[i].op, directed_rows[i].vector, directed_rows[i].token,
				directed_rows[i].context_word, directed_rows[i].fixed,
				directed_rows[i].answer);
		drain_results();

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			kind = phase_kind_t'($urandom_range(0, 3));
			phase_len = $urandom_range(20, 90);
			overflow_tries = 0;
			n = 0;
			// A fill phase runs until allocate has been refused three times, or for at most 400 requests.
			while (kind == PH_FILL ? (overflow_tries < 3 && n < 400) : n < phase_len) begin
				make_request(kind, op, vec, tok, ctx);
				if (op == OP_ALLOCATE && free_entries() == 0)
					overflow_tries++;
				offer(op, vec, tok, ctx, 1'b0, '0);
				n++;
				sent++;
			end
			if (!hold_active && $urandom_range(0, 2) == 0)
				drain_results();
		end

		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
